### rtl/xcrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package xcrc_pkg;

  // Control characters of the protocol
  localparam logic [7:0] ChSoh = 8'h01;
  localparam logic [7:0] ChStx = 8'h02;
  localparam logic [7:0] ChEot = 8'h04;
  localparam logic [7:0] ChAck = 8'h06;
  localparam logic [7:0] ChNak = 8'h15;
  localparam logic [7:0] ChCan = 8'h18;
  localparam logic [7:0] ChReq = 8'h43;

  localparam logic [10:0] ShortLen = 11'd128;
  localparam logic [10:0] LongLen  = 11'd1024;
  localparam logic [15:0] CrcPoly  = 16'h1021;

  localparam logic [16:0] TimerMax = 17'h1FFFF;
  localparam logic [8:0]  RetryMax = 9'd511;
  localparam logic [8:0]  RetryForever = 9'h1FF;

  // Configuration register indexes
  localparam logic [1:0] RegRetryLimit   = 2'd0;
  localparam logic [1:0] RegStartInterval = 2'd1;
  localparam logic [1:0] RegIdleTimeout  = 2'd2;

  localparam logic [8:0]  RetryLimitRst    = 9'd10;
  localparam logic [15:0] StartIntervalRst = 16'd3000;
  localparam logic [15:0] IdleTimeoutRst   = 16'd10000;

  // Packet events and finish codes
  localparam logic [1:0] EvNone    = 2'd0;
  localparam logic [1:0] EvCommit  = 2'd1;
  localparam logic [1:0] EvDiscard = 2'd2;

  localparam logic [1:0] StOk        = 2'd0;
  localparam logic [1:0] StCancelled = 2'd1;
  localparam logic [1:0] StRetry     = 2'd2;
  localparam logic [1:0] StTimeout   = 2'd3;

  // Input selector codes
  localparam logic [1:0] ModeByte    = 2'd0;
  localparam logic [1:0] ModeTick    = 2'd1;
  localparam logic [1:0] ModeRestart = 2'd2;

  localparam int QueueDepth = 4;
  localparam int QueueAw    = $clog2(QueueDepth);

  localparam int InDataW  = 24;
  localparam int OutDataW = 88;

  typedef enum logic [1:0] {
    KIND_BYTE,
    KIND_TICK,
    KIND_RESTART,
    KIND_NONE
  } kind_e;

  typedef enum logic [2:0] {
    CLS_SOH,
    CLS_STX,
    CLS_EOT,
    CLS_CAN,
    CLS_OTHER
  } cls_e;

  // One classified item on its way from the front to the back
  typedef struct packed {
    kind_e       kind;
    cls_e        cls;
    logic [7:0]  rx_byte;
    logic [9:0]  elapsed_ms;
    logic        sink_refuses;
  } item_t;

  // CRC-16/XMODEM over one byte, MSB first
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/xmodem_crc_receiver_unit.sv
// Path: an accepted input beat is stored in the queue, then processed and held in the result register for m_axis.
// Throughput: one item per cycle unless m_axis stalls; the back end does the CRC byte step
// and the state update for one queued item each cycle, behind a four-entry queue.
// Reset: rst_ni clears the queue, the result valid flag and the receiver state; the
// configuration registers return to retry limit 10, start interval 3000, timeout 10000.
`timescale 1ns / 1ps
`default_nettype none

module xmodem_crc_receiver_unit
  import xcrc_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [1:0]           cfg_addr_i,
  input  wire logic [15:0]          cfg_wdata_i,
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  // [7:0] rx_byte, [17:8] elapsed_ms, [18] sink_refuses, [23:19] zero
  input  wire logic [InDataW-1:0]   s_axis_tdata_i,
  // [1:0] mode
  input  wire logic [1:0]           s_axis_tuser_i,
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  // [0] data_valid, [8:1] data_byte, [40:9] data_offset, [42:41] packet_event,
  // [43] reply_valid, [51:44] reply_byte, [52] finish_valid, [54:53] finish_status,
  // [86:55] transferred_bytes, [87] zero
  output logic [OutDataW-1:0]       m_axis_tdata_o
);

  logic  head_valid;
  item_t head;
  logic  pop;

  xcrc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .head_valid_o    (head_valid),
    .head_o          (head),
    .pop_i           (pop)
  );

  xcrc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .head_valid_i    (head_valid),
    .head_i          (head),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

`default_nettype wire

### rtl/xcrc_front.sv
`timescale 1ns / 1ps
`default_nettype none

module xcrc_front
  import xcrc_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  wire logic [InDataW-1:0]   s_axis_tdata_i,
  input  wire logic [1:0]           s_axis_tuser_i,
  output logic                      head_valid_o,
  output item_t                     head_o,
  input  wire logic                 pop_i
);

  item_t               mem_q [QueueDepth];
  logic [QueueAw-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QueueAw-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QueueAw:0]    cnt_q, cnt_d;
  logic                push;
  logic                pop;
  item_t               item;

  // Classify the incoming beat
  always_comb begin
    item.rx_byte      = s_axis_tdata_i[7:0];
    item.elapsed_ms   = s_axis_tdata_i[17:8];
    item.sink_refuses = s_axis_tdata_i[18];
    unique case (s_axis_tuser_i)
      ModeByte:    item.kind = KIND_BYTE;
      ModeTick:    item.kind = KIND_TICK;
      ModeRestart: item.kind = KIND_RESTART;
      default:     item.kind = KIND_NONE;
    endcase
    unique case (s_axis_tdata_i[7:0])
      ChSoh:   item.cls = CLS_SOH;
      ChStx:   item.cls = CLS_STX;
      ChEot:   item.cls = CLS_EOT;
      ChCan:   item.cls = CLS_CAN;
      default: item.cls = CLS_OTHER;
    endcase
  end

  assign s_axis_tready_o = (cnt_q != (QueueAw+1)'(QueueDepth));
  assign push            = s_axis_tvalid_i && s_axis_tready_o;
  assign pop             = pop_i && (cnt_q != '0);
  assign head_valid_o    = (cnt_q != '0);
  assign head_o          = mem_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the classified beat
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QueueAw+1)'(QueueDepth))
    else $error("queue fill count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("back pops an empty queue");

endmodule

`default_nettype wire

### rtl/xcrc_back.sv
`timescale 1ns / 1ps
`default_nettype none

module xcrc_back
  import xcrc_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [1:0]           cfg_addr_i,
  input  wire logic [15:0]          cfg_wdata_i,
  input  wire logic                 head_valid_i,
  input  item_t                     head_i,
  output logic                      pop_o,
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  output logic [OutDataW-1:0]       m_axis_tdata_o
);

  localparam logic [2:0] PhWaitStart  = 3'd0;
  localparam logic [2:0] PhWaitPacket = 3'd1;
  localparam logic [2:0] PhInPacket   = 3'd2;
  localparam logic [2:0] PhFinished   = 3'd3;
  localparam logic [2:0] PhError      = 3'd4;

  logic [8:0]  limit_q;
  logic [15:0] interval_q;
  logic [15:0] timeout_q;

  logic [2:0]  phase_q, phase_d;
  logic [7:0]  exp_seq_q, exp_seq_d;
  logic [31:0] offset_q, offset_d;
  logic [10:0] cnt_q, cnt_d;
  logic        long_q, long_d;
  logic [7:0]  seq_q, seq_d;
  logic [7:0]  seq_n_q, seq_n_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] crc_rx_q, crc_rx_d;
  logic [8:0]  retry_q, retry_d;
  logic [16:0] st_tmr_q, st_tmr_d;
  logic [16:0] idle_tmr_q, idle_tmr_d;

  logic        out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  logic        r_dv, r_rv, r_fv;
  logic [7:0]  r_db, r_rb;
  logic [31:0] r_doff;
  logic [1:0]  r_ev, r_fs;

  logic [10:0] len;
  logic [15:0] crc_rx_full;
  logic [8:0]  retry_inc;
  logic [17:0] st_sum, idle_sum;
  logic [16:0] st_sat, idle_sat;
  logic        good, seq_cur, stop;

  assign pop_o = head_valid_i && (!out_valid_q || m_axis_tready_i);

  assign len         = long_q ? LongLen : ShortLen;
  assign crc_rx_full = {crc_rx_q[15:8], head_i.rx_byte};
  assign retry_inc   = (retry_q != RetryMax) ? retry_q + 9'd1 : retry_q;
  assign st_sum      = {1'b0, st_tmr_q} + {8'd0, head_i.elapsed_ms};
  assign idle_sum    = {1'b0, idle_tmr_q} + {8'd0, head_i.elapsed_ms};
  assign st_sat      = st_sum[17] ? TimerMax : st_sum[16:0];
  assign idle_sat    = idle_sum[17] ? TimerMax : idle_sum[16:0];
  assign seq_cur     = (seq_q == exp_seq_q);
  assign good        = (seq_q == ~seq_n_q) && (crc_q == crc_rx_full) &&
                       (seq_cur || (seq_q == exp_seq_q - 8'd1));

  // Hold configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q    <= RetryLimitRst;
      interval_q <= StartIntervalRst;
      timeout_q  <= IdleTimeoutRst;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        RegRetryLimit:    limit_q    <= cfg_wdata_i[8:0];
        RegStartInterval: interval_q <= cfg_wdata_i;
        RegIdleTimeout:   timeout_q  <= cfg_wdata_i;
        default:          ;
      endcase
    end
  end

  // Process the head item
  always_comb begin
    phase_d    = phase_q;
    exp_seq_d  = exp_seq_q;
    offset_d   = offset_q;
    cnt_d      = cnt_q;
    long_d     = long_q;
    seq_d      = seq_q;
    seq_n_d    = seq_n_q;
    crc_d      = crc_q;
    crc_rx_d   = crc_rx_q;
    retry_d    = retry_q;
    st_tmr_d   = st_tmr_q;
    idle_tmr_d = idle_tmr_q;
    stop       = 1'b0;
    r_dv   = 1'b0;
    r_db   = 8'd0;
    r_doff = 32'd0;
    r_ev   = EvNone;
    r_rv   = 1'b0;
    r_rb   = 8'd0;
    r_fv   = 1'b0;
    r_fs   = StOk;
    if (pop_o) begin
      case (head_i.kind)
        KIND_BYTE: begin
          idle_tmr_d = '0;
          if (phase_q == PhWaitStart || phase_q == PhWaitPacket) begin
            case (head_i.cls)
              CLS_SOH, CLS_STX: begin
                long_d  = (head_i.cls == CLS_STX);
                cnt_d   = 11'd1;
                crc_d   = '0;
                phase_d = PhInPacket;
              end
              CLS_EOT: begin
                r_rv    = 1'b1;
                r_rb    = ChAck;
                phase_d = PhFinished;
                r_fv    = 1'b1;
                r_fs    = StOk;
              end
              CLS_CAN: begin
                phase_d = PhError;
                r_fv    = 1'b1;
                r_fs    = StCancelled;
              end
              default: ;
            endcase
          end else if (phase_q == PhInPacket) begin
            cnt_d = cnt_q + 11'd1;
            if (cnt_q <= 11'd1) begin
              seq_d = head_i.rx_byte;
            end else if (cnt_q == 11'd2) begin
              seq_n_d = head_i.rx_byte;
            end else if (cnt_q < len + 11'd3) begin
              crc_d  = crc_byte(crc_q, head_i.rx_byte);
              r_dv   = 1'b1;
              r_db   = head_i.rx_byte;
              r_doff = offset_q + {21'd0, cnt_q - 11'd3};
            end else if (cnt_q == len + 11'd3) begin
              crc_rx_d = {head_i.rx_byte, 8'h00};
            end else begin
              // Close the packet and answer
              cnt_d    = cnt_q;
              crc_rx_d = crc_rx_full;
              r_ev     = EvDiscard;
              r_rv     = 1'b1;
              phase_d  = PhWaitPacket;
              if (good) begin
                if (seq_cur && !head_i.sink_refuses) begin
                  offset_d  = offset_q + {21'd0, len};
                  exp_seq_d = exp_seq_q + 8'd1;
                  retry_d   = '0;
                  r_rb      = ChAck;
                  r_ev      = EvCommit;
                end else if (seq_cur) begin
                  r_rb = ChNak;
                end else begin
                  r_rb = ChAck;
                end
              end else begin
                retry_d = retry_inc;
                if (limit_q != RetryForever &&
                    (limit_q[8] || retry_inc > {1'b0, limit_q[7:0]})) begin
                  r_rb    = ChCan;
                  phase_d = PhError;
                  r_fv    = 1'b1;
                  r_fs    = StRetry;
                end else begin
                  r_rb = ChNak;
                end
              end
            end
          end
        end
        KIND_TICK: begin
          st_tmr_d   = st_sat;
          idle_tmr_d = idle_sat;
          if (phase_q == PhWaitStart && st_sat >= {1'b0, interval_q}) begin
            if (limit_q == RetryForever ||
                (!limit_q[8] && retry_q < {1'b0, limit_q[7:0]})) begin
              r_rv     = 1'b1;
              r_rb     = ChReq;
              retry_d  = retry_inc;
              st_tmr_d = '0;
            end else begin
              phase_d = PhError;
              r_fv    = 1'b1;
              r_fs    = StRetry;
              stop    = 1'b1;
            end
          end
          if (!stop && phase_q <= PhInPacket && idle_sat > {1'b0, timeout_q}) begin
            phase_d = PhError;
            r_fv    = 1'b1;
            r_fs    = StTimeout;
          end
        end
        KIND_RESTART: begin
          phase_d    = PhWaitStart;
          exp_seq_d  = 8'd1;
          offset_d   = '0;
          cnt_d      = '0;
          long_d     = 1'b0;
          seq_d      = '0;
          seq_n_d    = '0;
          crc_d      = '0;
          crc_rx_d   = '0;
          retry_d    = '0;
          st_tmr_d   = {1'b0, interval_q};
          idle_tmr_d = '0;
        end
        default: ;
      endcase
    end
  end

  // Advance receiver state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhWaitStart;
      exp_seq_q  <= 8'd1;
      offset_q   <= '0;
      cnt_q      <= '0;
      long_q     <= 1'b0;
      seq_q      <= '0;
      seq_n_q    <= '0;
      crc_q      <= '0;
      crc_rx_q   <= '0;
      retry_q    <= '0;
      st_tmr_q   <= {1'b0, StartIntervalRst};
      idle_tmr_q <= '0;
    end else begin
      phase_q    <= phase_d;
      exp_seq_q  <= exp_seq_d;
      offset_q   <= offset_d;
      cnt_q      <= cnt_d;
      long_q     <= long_d;
      seq_q      <= seq_d;
      seq_n_q    <= seq_n_d;
      crc_q      <= crc_d;
      crc_rx_q   <= crc_rx_d;
      retry_q    <= retry_d;
      st_tmr_q   <= st_tmr_d;
      idle_tmr_q <= idle_tmr_d;
    end
  end

  // Hold the result beat until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_data_q <= {1'b0, offset_d, r_fs, r_fv, r_rb, r_rv, r_ev, r_doff, r_db, r_dv};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  a_pop_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> out_valid_q)
    else $error("processed item left no result beat");

  a_commit_clears_retry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && r_ev == EvCommit) |=> retry_q == '0)
    else $error("commit did not clear retry count");

  a_pkt_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhInPacket |-> (cnt_q != '0 && cnt_q <= LongLen + 11'd4))
    else $error("packet byte count out of range");

endmodule

`default_nettype wire

### test/xmodem_crc_receiver_unit_tb.sv
`timescale 1ns / 1ps

module xmodem_crc_receiver_unit_tb;
  import xcrc_pkg::*;

  localparam logic [1:0] ModeUnused = 2'd3;

  typedef enum logic [2:0] {
    RX_WAIT_START,
    RX_WAIT_PACKET,
    RX_IN_PACKET,
    RX_FINISHED,
    RX_ERROR
  } rx_phase_e;

  typedef enum int {
    FLAW_NONE,
    FLAW_CMP,
    FLAW_CRC
  } pkt_flaw_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] rx_byte;
    logic [9:0] elapsed;
    logic       refuses;
  } rx_item_t;

  // Result beat, laid out to match m_axis_tdata_o
  typedef struct packed {
    logic        pad;
    logic [31:0] transferred;
    logic [1:0]  fin_status;
    logic        fin_valid;
    logic [7:0]  reply_byte;
    logic        reply_valid;
    logic [1:0]  pkt_event;
    logic [31:0] data_offset;
    logic [7:0]  data_byte;
    logic        data_valid;
  } outcome_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [1:0]          cfg_addr_i = '0;
  logic [15:0]         cfg_wdata_i = '0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i = '0;
  logic [1:0]          s_axis_tuser_i = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;

  xmodem_crc_receiver_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  rx_item_t rx_items_q[$];
  outcome_t outcomes_q[$];
  rx_item_t cur_item;
  int       send_gap = 0;
  int       stall_left = 0;
  bit       quiet = 1'b0;
  int       mismatches = 0;
  int       results_seen = 0;
  int       phase_items = 0;
  logic [7:0] gen_seq = 8'd1;
  int       long_quota = 3;

  // Receiver shadow: configuration and state
  int          retry_cap;
  logic [15:0] start_ivl;
  logic [15:0] idle_limit;
  rx_phase_e   rx_phase;
  logic [7:0]  next_seq;
  logic [31:0] committed;
  logic [10:0] pkt_pos;
  logic        is_long;
  logic [7:0]  hdr_seq;
  logic [7:0]  hdr_cmp;
  logic [15:0] crc_calc;
  logic [15:0] crc_got;
  logic [8:0]  retries;
  logic [16:0] start_ms;
  logic [16:0] idle_ms;

  function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] b);
    logic [15:0] r;
    r = c;
    for (int i = 7; i >= 0; i--) begin
      r = (r[15] ^ b[i]) ? ({r[14:0], 1'b0} ^ CrcPoly) : {r[14:0], 1'b0};
    end
    return r;
  endfunction

  function automatic logic [16:0] timer_sum(input logic [16:0] t, input logic [9:0] d);
    logic [17:0] s;
    s = t + d;
    return (s > TimerMax) ? TimerMax : s[16:0];
  endfunction

  task automatic clear_receiver();
    rx_phase = RX_WAIT_START;
    next_seq = 8'd1;
    committed = '0;
    pkt_pos = '0;
    is_long = 1'b0;
    hdr_seq = '0;
    hdr_cmp = '0;
    crc_calc = '0;
    crc_got = '0;
    retries = '0;
    start_ms = {1'b0, start_ivl};
    idle_ms = '0;
  endtask

  // Work out the result beat of one accepted item and advance the shadow
  task automatic advance_receiver(input rx_item_t it);
    outcome_t r;
    int plen;
    int pos;
    bit good;
    bit stop;
    r = '0;
    case (it.mode)
      ModeByte: begin
        idle_ms = '0;
        if (rx_phase == RX_WAIT_START || rx_phase == RX_WAIT_PACKET) begin
          if (it.rx_byte == ChSoh || it.rx_byte == ChStx) begin
            is_long = (it.rx_byte == ChStx);
            pkt_pos = 11'd1;
            crc_calc = '0;
            rx_phase = RX_IN_PACKET;
          end else if (it.rx_byte == ChEot) begin
            r.reply_valid = 1'b1;
            r.reply_byte = ChAck;
            r.fin_valid = 1'b1;
            r.fin_status = StOk;
            rx_phase = RX_FINISHED;
          end else if (it.rx_byte == ChCan) begin
            r.fin_valid = 1'b1;
            r.fin_status = StCancelled;
            rx_phase = RX_ERROR;
          end
        end else if (rx_phase == RX_IN_PACKET) begin
          plen = is_long ? 1024 : 128;
          pos = pkt_pos;
          if (pos <= 1) begin
            hdr_seq = it.rx_byte;
          end else if (pos == 2) begin
            hdr_cmp = it.rx_byte;
          end else if (pos < plen + 3) begin
            crc_calc = crc16_step(crc_calc, it.rx_byte);
            r.data_valid = 1'b1;
            r.data_byte = it.rx_byte;
            r.data_offset = committed + 32'(pos - 3);
          end else if (pos == plen + 3) begin
            crc_got = {it.rx_byte, 8'h00};
          end else begin
            crc_got[7:0] = it.rx_byte;
            good = (hdr_seq == ~hdr_cmp) && (crc_calc == crc_got) &&
                   (hdr_seq == next_seq || hdr_seq == next_seq - 8'd1);
            r.pkt_event = EvDiscard;
            r.reply_valid = 1'b1;
            rx_phase = RX_WAIT_PACKET;
            if (good) begin
              if (hdr_seq == next_seq && !it.refuses) begin
                committed = committed + 32'(plen);
                next_seq = next_seq + 8'd1;
                retries = '0;
                r.reply_byte = ChAck;
                r.pkt_event = EvCommit;
              end else if (hdr_seq == next_seq) begin
                r.reply_byte = ChNak;
              end else begin
                r.reply_byte = ChAck;
              end
            end else begin
              if (retries != RetryMax) retries = retries + 9'd1;
              if (retry_cap != -1 && int'(retries) > retry_cap) begin
                r.reply_byte = ChCan;
                r.fin_valid = 1'b1;
                r.fin_status = StRetry;
                rx_phase = RX_ERROR;
              end else begin
                r.reply_byte = ChNak;
              end
            end
          end
          if (rx_phase == RX_IN_PACKET) pkt_pos = pkt_pos + 11'd1;
        end
      end
      ModeTick: begin
        stop = 1'b0;
        start_ms = timer_sum(start_ms, it.elapsed);
        idle_ms = timer_sum(idle_ms, it.elapsed);
        if (rx_phase == RX_WAIT_START && start_ms >= {1'b0, start_ivl}) begin
          if (retry_cap == -1 || int'(retries) < retry_cap) begin
            r.reply_valid = 1'b1;
            r.reply_byte = ChReq;
            if (retries != RetryMax) retries = retries + 9'd1;
            start_ms = '0;
          end else begin
            r.fin_valid = 1'b1;
            r.fin_status = StRetry;
            rx_phase = RX_ERROR;
            stop = 1'b1;
          end
        end
        if (!stop && rx_phase <= RX_IN_PACKET && idle_ms > {1'b0, idle_limit}) begin
          r.fin_valid = 1'b1;
          r.fin_status = StTimeout;
          rx_phase = RX_ERROR;
        end
      end
      ModeRestart: clear_receiver();
      default: ;
    endcase
    r.transferred = committed;
    outcomes_q.push_back(r);
  endtask

  // Sender: present items from the queue, with random gaps
  always @(posedge clk_i) begin : drive_rx
    bit fire;
    bit hold_valid;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      fire = s_axis_tvalid_i && s_axis_tready_o;
      if (fire) advance_receiver(cur_item);
      hold_valid = s_axis_tvalid_i && !fire;
      if (!hold_valid) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (rx_items_q.size() != 0) begin
          if (!quiet && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(0, 2);
          end else begin
            cur_item = rx_items_q.pop_front();
            s_axis_tdata_i <= {5'd0, cur_item.refuses, cur_item.elapsed, cur_item.rx_byte};
            s_axis_tuser_i <= cur_item.mode;
            hold_valid = 1'b1;
          end
        end
      end
      s_axis_tvalid_i <= hold_valid;
    end
  end

  // Receiver side: stall in short random bursts
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      m_axis_tready_i <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 2);
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("result %0d: %s expected 0x%0h got 0x%0h", results_seen, name, want, got);
      end
    end
  endtask

  // Compare each result beat with the oldest expectation
  always @(posedge clk_i) begin : watch_results
    outcome_t got;
    outcome_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = outcome_t'(m_axis_tdata_o);
      if (outcomes_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result %0d: beat with nothing expected", results_seen);
      end else begin
        want = outcomes_q.pop_front();
        check_field("data_valid", want.data_valid, got.data_valid);
        check_field("data_byte", want.data_byte, got.data_byte);
        check_field("data_offset", want.data_offset, got.data_offset);
        check_field("packet_event", want.pkt_event, got.pkt_event);
        check_field("reply_valid", want.reply_valid, got.reply_valid);
        check_field("reply_byte", want.reply_byte, got.reply_byte);
        check_field("finish_valid", want.fin_valid, got.fin_valid);
        check_field("finish_status", want.fin_status, got.fin_status);
        check_field("transferred_bytes", want.transferred, got.transferred);
      end
      results_seen++;
    end
  end

  task automatic push_item(input logic [1:0] mode, input logic [7:0] b,
                           input logic [9:0] el, input logic refuses);
    rx_item_t it;
    it.mode = mode;
    it.rx_byte = b;
    it.elapsed = el;
    it.refuses = refuses;
    rx_items_q.push_back(it);
    phase_items++;
  endtask

  task automatic push_tick(input logic [9:0] el);
    push_item(ModeTick, 8'($urandom_range(0, 255)), el, 1'($urandom_range(0, 1)));
  endtask

  task automatic push_byte(input logic [7:0] b);
    push_item(ModeByte, b, 10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
  endtask

  // Frame one packet; a nonzero cut stops it after that many bytes
  task automatic queue_packet(input bit lng, input logic [7:0] seq, input pkt_flaw_e flaw,
                              input bit refuse, input int cut);
    logic [7:0]  frame[$];
    logic [15:0] crc;
    logic [7:0]  b;
    int          n;
    int          last;
    n = lng ? 1024 : 128;
    crc = '0;
    frame.push_back(lng ? ChStx : ChSoh);
    frame.push_back(seq);
    frame.push_back(flaw == FLAW_CMP ? ~seq ^ 8'($urandom_range(1, 255)) : ~seq);
    repeat (n) begin
      b = 8'($urandom_range(0, 255));
      crc = crc16_step(crc, b);
      frame.push_back(b);
    end
    if (flaw == FLAW_CRC) crc = crc ^ 16'($urandom_range(1, 65535));
    frame.push_back(crc[15:8]);
    frame.push_back(crc[7:0]);
    last = (cut > 0 && cut < frame.size()) ? cut : frame.size();
    for (int i = 0; i < last; i++) begin
      if (i == frame.size() - 1) begin
        push_item(ModeByte, frame[i], 10'($urandom_range(0, 1023)), refuse);
      end else begin
        push_byte(frame[i]);
      end
    end
  endtask

  // One transfer: restart, maybe a start request, a few packets, then maybe a close
  task automatic queue_session();
    logic [7:0] seq;
    pkt_flaw_e  flaw;
    bit         refuse;
    bit         lng;
    bit         broken;
    int         npk;
    int         pick;
    push_item(ModeRestart, 8'($urandom_range(0, 255)), 10'($urandom_range(0, 1023)), 1'b0);
    gen_seq = 8'd1;
    if ($urandom_range(0, 1)) push_tick(10'($urandom_range(0, 40)));
    npk = $urandom_range(1, 4);
    broken = 1'b0;
    while (npk > 0 && !broken) begin
      npk--;
      pick = $urandom_range(0, 99);
      seq = gen_seq;
      flaw = FLAW_NONE;
      refuse = 1'b0;
      lng = 1'b0;
      if (long_quota > 0 && $urandom_range(0, 19) == 0) begin
        lng = 1'b1;
        long_quota--;
      end
      if (pick >= 92) begin
        queue_packet(1'b0, seq, FLAW_NONE, 1'b0, $urandom_range(1, 130));
        broken = 1'b1;
      end else begin
        if (pick >= 84) seq = gen_seq + 8'($urandom_range(1, 253));
        else if (pick >= 76) flaw = FLAW_CMP;
        else if (pick >= 68) flaw = FLAW_CRC;
        else if (pick >= 60) refuse = 1'b1;
        else if (pick >= 50) seq = gen_seq - 8'd1;
        queue_packet(lng, seq, flaw, refuse, 0);
        if (seq == gen_seq && flaw == FLAW_NONE && !refuse) gen_seq = gen_seq + 8'd1;
        if ($urandom_range(0, 3) == 0) push_tick(10'($urandom_range(0, 3)));
        if ($urandom_range(0, 7) == 0) push_byte(8'($urandom_range(8'h20, 8'hFF)));
      end
    end
    if (!broken) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) push_byte(ChEot);
      else if (pick < 75) push_byte(ChCan);
    end
  endtask

  task automatic queue_noise(input int n);
    repeat (n) begin
      push_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic queue_random(input int budget);
    phase_items = 0;
    while (phase_items < budget) begin
      queue_session();
      queue_noise($urandom_range(0, 2));
    end
  endtask

  // Hold until every item is sent and every result has come back
  task automatic wait_drained();
    while (rx_items_q.size() != 0 || s_axis_tvalid_i || outcomes_q.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      RegRetryLimit:    retry_cap = $signed(val[8:0]);
      RegStartInterval: start_ivl = val;
      RegIdleTimeout:   idle_limit = val;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [8:0] lim, input logic [15:0] ivl,
                                input logic [15:0] idle);
    wait_drained();
    write_reg(RegRetryLimit, {7'd0, lim});
    write_reg(RegStartInterval, ivl);
    write_reg(RegIdleTimeout, idle);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    retry_cap = $signed(RetryLimitRst);
    start_ivl = StartIntervalRst;
    idle_limit = IdleTimeoutRst;
    clear_receiver();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: start request, ignored items, cancel, end of transfer, idle timeout
    push_tick(10'd0);
    push_item(ModeUnused, 8'hFF, 10'h3FF, 1'b1);
    push_byte(8'hFF);
    push_byte(8'h00);
    repeat (3) push_tick(10'd1023);
    push_byte(ChCan);
    push_tick(10'd1023);
    push_byte(ChEot);
    push_item(ModeRestart, 8'h00, 10'd0, 1'b0);
    push_byte(ChEot);
    push_tick(10'd0);
    push_item(ModeRestart, 8'hFF, 10'h3FF, 1'b1);
    repeat (10) push_tick(10'd1023);
    push_item(ModeRestart, 8'h00, 10'd0, 1'b0);
    queue_random(400);

    // Retry forever, fastest start requests: drive the retry count to saturation
    apply_settings(9'h1FF, 16'd1, 16'hFFFF);
    push_item(ModeRestart, 8'h00, 10'd0, 1'b0);
    repeat (520) push_tick(10'd1);
    queue_packet(1'b0, 8'd1, FLAW_CRC, 1'b0, 0);
    queue_random(300);

    // Largest limit and intervals: saturate both timers after the transfer ends
    apply_settings(9'd255, 16'hFFFF, 16'hFFFF);
    push_item(ModeRestart, 8'h00, 10'd0, 1'b0);
    push_byte(ChEot);
    repeat (130) push_tick(10'd1023);
    queue_random(300);

    // No retries at all, shortest intervals
    apply_settings(9'd0, 16'd1, 16'd1);
    queue_random(250);

    // Most negative limit never allows a start request
    apply_settings(9'h100, 16'd2, 16'd200);
    queue_random(250);

    apply_settings(9'd2, 16'd500, 16'd2000);
    queue_random(300);

    // Last stretch runs back to back on both sides
    apply_settings(9'd3, 16'd3000, 16'd10000);
    quiet = 1'b1;
    queue_random(150);

    wait_drained();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && outcomes_q.size() == 0) begin
      $display("xmodem_crc_receiver_unit verification clean");
    end else begin
      $display("xmodem_crc_receiver_unit verification failed");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("xmodem_crc_receiver_unit verification failed");
    $finish;
  end

endmodule
